FILE: hdl/wmbus_fa_pkg.sv
// Shared types, constants and the CRC-16 byte update for the format A frame checker.
package wmbus_fa_pkg;

    // CRC-16 for wireless M-Bus: polynomial, start value and MSB tap
    localparam logic [15:0] CRC_POLY    = 16'h3D65;
    localparam logic [15:0] CRC_INIT    = 16'h0000;
    localparam logic [15:0] CRC_TOP_BIT = 16'h8000;

    // Frame layout: block lengths include the two CRC bytes
    localparam logic [7:0] MIN_FRAME_LEN   = 8'd13;
    localparam logic [5:0] FIRST_BLOCK_LEN = 6'd12;
    localparam logic [5:0] LATER_BLOCK_LEN = 6'd18;
    localparam int unsigned HDR_LEN        = 10;

    // One input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } frame_byte_t;

    // One result beat
    typedef struct packed {
        logic        frame_valid;
        logic [7:0]  l_field;
        logic [7:0]  c_field;
        logic [15:0] m_field;
        logic [31:0] a_id;
        logic [7:0]  a_version;
        logic [7:0]  a_type;
    } frame_result_t;

    // Eight bit steps of the MSB-first CRC register, unrolled
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [15:0] r;
        logic [7:0]  d;
        logic        fb;
        r = crc_in;
        d = data_in;
        for (int k = 0; k < 8; k++)
        begin
            fb = ((r & CRC_TOP_BIT) != 16'h0000) ^ d[7];
            r  = {r[14:0], 1'b0};
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
            d = {d[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: hdl/wmbus_frame_a_checker.sv
// Wireless M-Bus format A frame checker: block CRC checks and header capture.
//
// Bytes of one frame enter on the data channel, one per beat, with last_byte
// set on the final byte. The first block is 10 data bytes plus a CRC-16
// (poly 0x3D65, init 0, inverted, high byte first); later blocks are 16 data
// bytes plus CRC, and a final partial block is allowed. On the final byte one
// result beat gives frame_valid and the header fields (L, C, M, A id, version,
// type), all zero for an invalid frame. Frames shorter than 13 bytes, longer
// than MAX_FRAME_LEN, or ending in a one-byte block are invalid. Throughput is
// one byte per clock: each beat is captured in an input register, the CRC byte
// update and compare run combinationally against the per-frame state, and the
// verdict lands in the result register. The only stall comes from a result beat
// that is not taken.
module wmbus_frame_a_checker
    import wmbus_fa_pkg::*;
#(
    parameter int unsigned MAX_FRAME_LEN = 255
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          data_valid,
    output logic          data_ready,
    input  frame_byte_t   data,
    output logic          result_valid,
    input  logic          result_ready,
    output frame_result_t result
);

    localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LEN);

    // Input stage
    logic        in_valid_reg;
    frame_byte_t in_reg;

    // Per-frame state
    logic [7:0]  pos_reg,    pos_next;
    logic [4:0]  offset_reg, offset_next;
    logic [15:0] crc_reg,    crc_next;
    logic [15:0] held_reg,   held_next;
    logic        ok_reg,     ok_next;
    logic [7:0]  hdr_reg [HDR_LEN];

    // Result stage
    logic          out_valid_reg;
    frame_result_t out_reg, out_next;

    logic        fire;
    logic        block_end;
    logic        block_bad;
    logic [5:0]  offset_inc;
    logic [5:0]  block_len;
    logic [15:0] crc_upd;
    logic [15:0] held_upd;

    // Process the held beat unless its result would overwrite an untaken one
    assign fire       = in_valid_reg && (!in_reg.last_byte || !out_valid_reg || result_ready);
    assign data_ready = !in_valid_reg || fire;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (data_ready)
        begin
            in_valid_reg <= data_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_ready && data_valid)
        begin
            in_reg <= data;
        end
    end

    // Block tracking, CRC and verdict
    always_comb
    begin
        block_len  = (pos_reg < 8'(FIRST_BLOCK_LEN)) ? FIRST_BLOCK_LEN : LATER_BLOCK_LEN;
        crc_upd    = (offset_reg >= 5'd2) ? crc16_byte(crc_reg, held_reg[15:8]) : crc_reg;
        held_upd   = {held_reg[7:0], in_reg.data_byte};
        offset_inc = {1'b0, offset_reg} + 6'd1;
        block_end  = (offset_inc >= block_len) || in_reg.last_byte;
        block_bad  = (offset_inc < 6'd2) || (~crc_upd != held_upd);

        ok_next = ok_reg;
        if (pos_reg >= MaxLen)
        begin
            ok_next = 1'b0;
        end
        if (block_end && block_bad)
        begin
            ok_next = 1'b0;
        end
        // Short frame: length pos+1 below the minimum
        if (in_reg.last_byte && (pos_reg < (MIN_FRAME_LEN - 8'd1)))
        begin
            ok_next = 1'b0;
        end

        pos_next    = (pos_reg != 8'hFF) ? pos_reg + 8'd1 : pos_reg;
        offset_next = offset_inc[4:0];
        crc_next    = crc_upd;
        held_next   = held_upd;
        if (block_end)
        begin
            offset_next = 5'd0;
            crc_next    = CRC_INIT;
            held_next   = 16'h0000;
        end

        // Result beat, header gated by the verdict
        out_next = '0;
        if (ok_next)
        begin
            out_next.frame_valid = 1'b1;
            out_next.l_field     = hdr_reg[0];
            out_next.c_field     = hdr_reg[1];
            out_next.m_field     = {hdr_reg[3], hdr_reg[2]};
            out_next.a_id        = {hdr_reg[7], hdr_reg[6], hdr_reg[5], hdr_reg[4]};
            out_next.a_version   = hdr_reg[8];
            out_next.a_type      = hdr_reg[9];
        end
    end

    // Frame state registers, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 8'd0;
            offset_reg <= 5'd0;
            crc_reg    <= CRC_INIT;
            held_reg   <= 16'h0000;
            ok_reg     <= 1'b1;
        end
        else if (fire)
        begin
            if (in_reg.last_byte)
            begin
                pos_reg    <= 8'd0;
                offset_reg <= 5'd0;
                crc_reg    <= CRC_INIT;
                held_reg   <= 16'h0000;
                ok_reg     <= 1'b1;
            end
            else
            begin
                pos_reg    <= pos_next;
                offset_reg <= offset_next;
                crc_reg    <= crc_next;
                held_reg   <= held_next;
                ok_reg     <= ok_next;
            end
        end
    end

    // Header bytes 0..9 captured by position
    always_ff @(posedge clk)
    begin
        if (fire && (pos_reg < 8'(HDR_LEN)))
        begin
            hdr_reg[pos_reg[3:0]] <= in_reg.data_byte;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && in_reg.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_reg.last_byte)
        begin
            out_reg <= out_next;
        end
    end

    // Block offset stays inside the longest block
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, offset_reg} < LATER_BLOCK_LEN)
        else $error("block offset out of range");

    // An invalid verdict carries an all-zero header
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.frame_valid) |->
        (out_reg.l_field == 8'd0 && out_reg.c_field == 8'd0 && out_reg.m_field == 16'd0 &&
         out_reg.a_id == 32'd0 && out_reg.a_version == 8'd0 && out_reg.a_type == 8'd0))
        else $error("invalid frame reported with header data");

    // The final byte leaves the frame state cleared and a result pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_reg.last_byte) |=>
        (pos_reg == 8'd0 && offset_reg == 5'd0 && crc_reg == CRC_INIT && ok_reg && out_valid_reg))
        else $error("frame state not cleared after final byte");

    // A held beat that is not processed stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_reg)))
        else $error("stalled input beat lost");

    // A valid verdict needs at least the minimum frame length
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_reg.last_byte && (pos_reg < (MIN_FRAME_LEN - 8'd1))) |=>
        (out_valid_reg && !out_reg.frame_valid))
        else $error("short frame reported valid");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the wireless M-Bus format A frame checker.
module testbench;
    import wmbus_fa_pkg::*;

    localparam int unsigned LEN_LIMIT    = 255;
    localparam int unsigned BYTE_TARGET  = 1850;
    localparam int unsigned PHASE_CYCLES = 400;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SHOW_ERRORS  = 10;

    // Idle pattern of the two channels
    typedef enum logic [1:0] {
        PH_NONE,
        PH_SEND,
        PH_RECV,
        PH_BOTH
    } idle_phase_t;

    // Content of the data bytes of a generated frame
    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    // One byte waiting to be sent; wait_idle holds it until no verdict is pending
    typedef struct {
        frame_byte_t beat;
        bit          wait_idle;
    } pend_byte_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          data_valid = 1'b0;
    logic          data_ready;
    frame_byte_t   data = '0;
    logic          result_valid;
    logic          result_ready = 1'b0;
    frame_result_t result;

    pend_byte_t    pend_q[$];
    frame_result_t verdict_q[$];

    // Predicted frame state
    logic [7:0]    pos_count = '0;
    logic [4:0]    blk_count = '0;
    logic [15:0]   crc_acc = '0;
    logic [15:0]   tail_pair = '0;
    logic          ok_flag = 1'b1;
    logic [7:0]    hdr_bytes [HDR_LEN];

    idle_phase_t   idle_phase = PH_NONE;
    bit            byte_took = 1'b0;
    int unsigned   hold_left = 0;
    int unsigned   taken_cnt = 0;
    int unsigned   cycle_cnt = 0;
    int unsigned   bytes_in = 0;
    int unsigned   results_in = 0;
    int unsigned   valid_frames = 0;
    int unsigned   frames_queued = 0;
    int unsigned   fail_cnt = 0;

    wmbus_frame_a_checker #(
        .MAX_FRAME_LEN (LEN_LIMIT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data         (data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // MSB-first CRC-16 over one byte
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            if (r[15] ^ b[i])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_byte(input fill_t f);
        case (f)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom);
        endcase
    endfunction

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= SHOW_ERRORS)
            $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            note_failure($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                   results_in, name, want, got));
    endtask

    // Predictor: advance the frame state by one accepted byte
    task automatic predict_byte(input frame_byte_t beat);
        int unsigned   at;
        int unsigned   blk_len;
        int unsigned   n;
        frame_result_t v;
        at = 32'(pos_count);
        blk_len = (at < 32'(FIRST_BLOCK_LEN)) ? 32'(FIRST_BLOCK_LEN) : 32'(LATER_BLOCK_LEN);
        if (at >= LEN_LIMIT)
            ok_flag = 1'b0;
        if (at < HDR_LEN)
            hdr_bytes[4'(at)] = beat.data_byte;
        if (pos_count != 8'hFF)
            pos_count = pos_count + 8'd1;

        // CRC trails the input by two bytes so the CRC itself stays out of it
        if (blk_count >= 5'd2)
            crc_acc = crc_step(crc_acc, tail_pair[15:8]);
        tail_pair = {tail_pair[7:0], beat.data_byte};
        n = 32'(blk_count) + 1;
        blk_count = n[4:0];

        // Block end: full length or frame end
        if (n >= blk_len || beat.last_byte)
        begin
            if (n < 2 || (~crc_acc) != tail_pair)
                ok_flag = 1'b0;
            crc_acc = CRC_INIT;
            blk_count = '0;
            tail_pair = '0;
        end

        if (beat.last_byte)
        begin
            if (at + 1 < 32'(MIN_FRAME_LEN))
                ok_flag = 1'b0;
            v = '0;
            if (ok_flag)
            begin
                v.frame_valid = 1'b1;
                v.l_field     = hdr_bytes[0];
                v.c_field     = hdr_bytes[1];
                v.m_field     = {hdr_bytes[3], hdr_bytes[2]};
                v.a_id        = {hdr_bytes[7], hdr_bytes[6], hdr_bytes[5], hdr_bytes[4]};
                v.a_version   = hdr_bytes[8];
                v.a_type      = hdr_bytes[9];
            end
            verdict_q.push_back(v);
            pos_count = '0;
            blk_count = '0;
            crc_acc   = CRC_INIT;
            tail_pair = '0;
            ok_flag   = 1'b1;
        end
    endtask

    // Build one frame of len bytes; unless raw, every block longer than one byte carries a good CRC
    task automatic queue_frame(input int unsigned len, input fill_t f, input bit corrupt,
                               input bit raw, input bit wait_idle);
        logic [7:0]  body[$];
        logic [15:0] acc;
        int unsigned at;
        int unsigned blk_end;
        int unsigned flip;
        pend_byte_t  pb;
        at = 0;
        while (at < len)
        begin
            blk_end = at + ((at < FIRST_BLOCK_LEN) ? FIRST_BLOCK_LEN : LATER_BLOCK_LEN);
            if (blk_end > len)
                blk_end = len;
            if (raw || blk_end - at < 2)
            begin
                for (int unsigned p = at; p < blk_end; p++)
                    body.push_back(pick_byte(f));
            end
            else
            begin
                acc = CRC_INIT;
                for (int unsigned p = at; p + 2 < blk_end; p++)
                begin
                    body.push_back(pick_byte(f));
                    acc = crc_step(acc, body[$]);
                end
                body.push_back(~acc[15:8]);
                body.push_back(~acc[7:0]);
            end
            at = blk_end;
        end
        if (corrupt)
        begin
            flip = $urandom_range(len - 1);
            body[flip] = body[flip] ^ (8'h01 << $urandom_range(7));
        end
        for (int unsigned i = 0; i < len; i++)
        begin
            pb.beat.data_byte = body[i];
            pb.beat.last_byte = (i == len - 1);
            pb.wait_idle      = wait_idle && (i == 0);
            pend_q.push_back(pb);
        end
        frames_queued++;
    endtask

    // Cycle count, idle phase and run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        idle_phase <= idle_phase_t'((cycle_cnt / PHASE_CYCLES) % 4);
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d verdicts pending",
                     cycle_cnt, verdict_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Byte driver: new beat at the falling edge once the previous one is taken
    always @(negedge clk)
    begin : drive_bytes
        logic        nx_valid;
        frame_byte_t nx_beat;
        pend_byte_t  pb;
        int unsigned idle_pct;
        nx_valid = data_valid;
        nx_beat  = data;
        if (rst_n)
        begin
            if (data_valid && byte_took)
                nx_valid = 1'b0;
            idle_pct = (idle_phase == PH_SEND) ? 63 : (idle_phase == PH_BOTH) ? 17 : 0;
            if (!nx_valid && pend_q.size() != 0)
            begin
                if (!(pend_q[0].wait_idle && verdict_q.size() != 0) &&
                    $urandom_range(99) >= idle_pct)
                begin
                    pb = pend_q.pop_front();
                    nx_beat  = pb.beat;
                    nx_valid = 1'b1;
                end
            end
        end
        data_valid <= nx_valid;
        data       <= nx_beat;
    end

    // Long receiver hold-offs after the 8th and the 20th result
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            taken_cnt++;
            if (taken_cnt == 8 || taken_cnt == 20)
                hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result receiver: random stalls per phase
    always @(negedge clk)
    begin : drive_ready
        int unsigned stall_pct;
        stall_pct = (idle_phase == PH_RECV) ? 63 : (idle_phase == PH_BOTH) ? 17 : 0;
        result_ready <= rst_n && hold_left == 0 && $urandom_range(99) >= stall_pct;
    end

    // Monitor: predict on accepted bytes, compare accepted results
    always @(posedge clk)
    begin : watch_ports
        frame_result_t want;
        byte_took = rst_n && data_valid && data_ready;
        if (byte_took)
        begin
            predict_byte(data);
            bytes_in++;
        end
        if (rst_n && result_valid && result_ready)
        begin
            results_in++;
            if (result.frame_valid === 1'b1)
                valid_frames++;
            if (verdict_q.size() == 0)
            begin
                note_failure($sformatf("result %0d arrived with no frame pending", results_in));
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("frame_valid", 32'(result.frame_valid), 32'(want.frame_valid));
                check_field("l_field", 32'(result.l_field), 32'(want.l_field));
                check_field("c_field", 32'(result.c_field), 32'(want.c_field));
                check_field("m_field", 32'(result.m_field), 32'(want.m_field));
                check_field("a_id", result.a_id, want.a_id);
                check_field("a_version", 32'(result.a_version), 32'(want.a_version));
                check_field("a_type", 32'(result.a_type), 32'(want.a_type));
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : stimulus
        int unsigned k;
        int unsigned len;
        int unsigned idx;
        bit          raw;
        bit          corrupt;
        fill_t       f;

        // Directed: two-byte final block with all-ones data, one-byte frame,
        // one-byte final block
        queue_frame(14, FILL_ONES, 1'b0, 1'b0, 1'b0);
        queue_frame(1, FILL_RANDOM, 1'b0, 1'b0, 1'b1);
        queue_frame(13, FILL_ZERO, 1'b0, 1'b0, 1'b0);

        // Random frames, mostly well formed; first an over-long and a max-length one
        idx = 0;
        while (pend_q.size() < BYTE_TARGET)
        begin
            k = $urandom_range(99);
            raw = 1'b0;
            corrupt = ($urandom_range(99) < 20);
            if (idx == 0)
                len = 258;
            else if (idx == 1)
                len = LEN_LIMIT;
            else if (k < 8)
                len = $urandom_range(12, 1);
            else if (k < 14)
                len = 13 + 18 * $urandom_range(3);
            else if (k < 20)
                len = 14 + 18 * $urandom_range(3);
            else if (k < 26)
            begin
                raw = 1'b1;
                len = $urandom_range(40, 1);
            end
            else if (k < 28)
                len = $urandom_range(255, 180);
            else
                len = $urandom_range(70, 15);
            k = $urandom_range(19);
            f = (k == 0) ? FILL_ZERO : (k == 1) ? FILL_ONES : FILL_RANDOM;
            queue_frame(len, f, corrupt, raw, (idx % 12 == 5));
            idx++;
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Drain
        while (pend_q.size() != 0 || data_valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Run: %0d bytes in %0d frames, %0d verdicts checked (%0d valid frames),",
                 bytes_in, frames_queued, results_in, valid_frames);
        $display("under four idle patterns, two long result hold-offs and drain pauses.");
        if (fail_cnt == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("%0d mismatches", fail_cnt);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
